// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file of the tracker.
// Clock and reset are passed in; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion, disabled while reset is high
`define ART_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent assertion that also holds across reset
`define ART_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/art_pkg.sv
// Shared types and constants of the ack/retransmit tracker.
// Used by the datapath, the controller and the top level.
package art_pkg;

   localparam int ID_W    = 32;
   localparam int TIME_W  = 32;
   localparam int RC_W    = 4;
   localparam int TMO_W   = 8;
   localparam int KIND_W  = 3;
   localparam int ENTRY_W = ID_W + TIME_W + RC_W;
   localparam int REQ_W   = 40;
   localparam int RSP_W   = 40;
   localparam int CSR_AW  = 1;
   localparam int CSR_DW  = 8;

   localparam logic [1:0] OP_ADD  = 2'd0;
   localparam logic [1:0] OP_ACK  = 2'd1;
   localparam logic [1:0] OP_TICK = 2'd2;

   localparam logic [CSR_AW-1:0] CSR_RETRY_TIMEOUT = 1'b0;
   localparam logic [CSR_AW-1:0] CSR_MAX_RETRIES   = 1'b1;

   localparam logic [RC_W-1:0] RC_MAX = 4'd15;

   localparam logic [KIND_W-1:0] KIND_ADDED         = 3'd0;
   localparam logic [KIND_W-1:0] KIND_DROPPED       = 3'd1;
   localparam logic [KIND_W-1:0] KIND_ACK_MATCHED   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_ACK_UNMATCHED = 3'd3;
   localparam logic [KIND_W-1:0] KIND_RESEND        = 3'd4;
   localparam logic [KIND_W-1:0] KIND_GIVEN_UP      = 3'd5;
   localparam logic [KIND_W-1:0] KIND_TICK_IDLE     = 3'd6;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] sent;
      logic [RC_W-1:0]   retries;
   } entry_type;

   typedef enum logic [1:0] {
      WR_ADD    = 2'd0,
      WR_MOVE   = 2'd1,
      WR_RESEND = 2'd2
   } wr_sel_type;

   typedef enum logic [2:0] {
      OUT_NONE = 3'd0,
      OUT_ADD  = 3'd1,
      OUT_ACK  = 3'd2,
      OUT_EVAL = 3'd3,
      OUT_FIN  = 3'd4
   } out_sel_type;

   typedef struct packed {
      logic        latch;
      logic        found_set;
      logic        cnt_inc;
      logic        cnt_dec;
      logic        idx_clr;
      logic        idx_inc;
      logic        now_inc;
      logic        rd_en;
      logic        rd_tail;
      logic        wr_en;
      wr_sel_type  wr_sel;
      out_sel_type out_sel;
   } cmd_type;

   typedef struct packed {
      logic [1:0] req_op;
      logic       full;
      logic       idx_ge;
      logic       idx_is_tail;
      logic       match;
      logic       due;
      logic       give_up;
      logic       out_free;
      logic       pend_free;
   } stat_type;

endpackage

// File: rtl/core/art_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module art_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/core/art_datapath.sv
// Datapath of the tracker: table RAM, counters, config registers,
// pending result and output register. Depends on art_pkg and art_ram.
module art_datapath #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [art_pkg::REQ_W-1:0]  req_tdata,
   input  logic                     csr_we,
   input  logic [art_pkg::CSR_AW-1:0] csr_addr,
   input  logic [art_pkg::CSR_DW-1:0] csr_wdata,
   input  logic                     rsp_tready,
   input  art_pkg::cmd_type          cmd,
   output art_pkg::stat_type         stat,
   output logic                     rsp_tvalid,
   output logic [art_pkg::RSP_W-1:0]  rsp_tdata,
   output logic                     rsp_tlast
);
   import art_pkg::*;

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   logic [ID_W-1:0]   id_ff, id_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [TMO_W-1:0]  timeout_ff, timeout_in;
   logic [RC_W-1:0]   max_ff, max_in;
   logic              found_ff, found_in;

   logic              pend_valid_ff, pend_valid_in;
   logic [KIND_W-1:0] pend_kind_ff, pend_kind_in;
   logic [ID_W-1:0]   pend_id_ff, pend_id_in;
   logic [RC_W-1:0]   pend_rc_ff, pend_rc_in;

   logic              out_valid_ff, out_valid_in;
   logic [KIND_W-1:0] out_kind_ff, out_kind_in;
   logic [ID_W-1:0]   out_id_ff, out_id_in;
   logic [RC_W-1:0]   out_rc_ff, out_rc_in;
   logic              out_last_ff, out_last_in;

   entry_type         rd_q;
   entry_type         wr_d;
   logic [ENTRY_W-1:0] rdata;
   logic [AW-1:0]     waddr;
   logic [AW-1:0]     raddr;
   logic [CW-1:0]     tail;
   logic [TIME_W-1:0] age;
   logic [RC_W-1:0]   rc_next;
   logic              full;
   logic              out_free;

   art_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock (clock),
      .we    (cmd.wr_en),
      .waddr (waddr),
      .wdata (wr_d),
      .re    (cmd.rd_en),
      .raddr (raddr),
      .rdata (rdata)
   );

   assign rd_q     = entry_type'(rdata);
   assign tail     = CW'(count_ff - CW'(1));
   assign age      = now_ff - rd_q.sent;
   assign rc_next  = (rd_q.retries == RC_MAX) ? RC_MAX : rd_q.retries + RC_W'(1);
   assign full     = (count_ff == CW'(TABLE_DEPTH));
   assign out_free = !out_valid_ff || rsp_tready;
   assign raddr    = cmd.rd_tail ? tail[AW-1:0] : idx_ff[AW-1:0];
   assign waddr    = (cmd.wr_sel == WR_ADD) ? count_ff[AW-1:0] : idx_ff[AW-1:0];

   always_comb begin
      unique case (cmd.wr_sel)
         WR_ADD:    wr_d = '{id: id_ff, sent: now_ff, retries: '0};
         WR_MOVE:   wr_d = rd_q;
         WR_RESEND: wr_d = '{id: rd_q.id, sent: now_ff, retries: rc_next};
         default:   wr_d = rd_q;
      endcase
   end

   always_comb begin
      stat.req_op      = req_tdata[1:0];
      stat.full        = full;
      stat.idx_ge      = (idx_ff >= count_ff);
      stat.idx_is_tail = (idx_ff == tail);
      stat.match       = (rd_q.id == id_ff);
      stat.due         = (age >= TIME_W'(timeout_ff));
      stat.give_up     = (rc_next > max_ff);
      stat.out_free    = out_free;
      stat.pend_free   = !pend_valid_ff || out_free;
   end

   always_comb begin
      id_in      = cmd.latch ? req_tdata[33:2] : id_ff;
      found_in   = cmd.latch ? 1'b0 : (found_ff | cmd.found_set);
      count_in   = count_ff;
      if (cmd.cnt_inc) begin
         count_in = CW'(count_ff + CW'(1));
      end else if (cmd.cnt_dec) begin
         count_in = tail;
      end
      idx_in = idx_ff;
      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = CW'(idx_ff + CW'(1));
      end
      now_in     = cmd.now_inc ? now_ff + TIME_W'(1) : now_ff;
      timeout_in = timeout_ff;
      max_in     = max_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_RETRY_TIMEOUT: timeout_in = csr_wdata;
            CSR_MAX_RETRIES:   max_in     = csr_wdata[RC_W-1:0];
            default:           ;
         endcase
      end
   end

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_kind_in  = pend_kind_ff;
      pend_id_in    = pend_id_ff;
      pend_rc_in    = pend_rc_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_kind_in   = out_kind_ff;
      out_id_in     = out_id_ff;
      out_rc_in     = out_rc_ff;
      out_last_in   = out_last_ff;
      unique case (cmd.out_sel)
         OUT_NONE: ;
         OUT_ADD: begin
            out_valid_in = 1'b1;
            out_kind_in  = full ? KIND_DROPPED : KIND_ADDED;
            out_id_in    = id_ff;
            out_rc_in    = '0;
            out_last_in  = 1'b1;
         end
         OUT_ACK: begin
            out_valid_in = 1'b1;
            out_kind_in  = found_ff ? KIND_ACK_MATCHED : KIND_ACK_UNMATCHED;
            out_id_in    = id_ff;
            out_rc_in    = '0;
            out_last_in  = 1'b1;
         end
         OUT_EVAL: begin
            // previous pending result is known not to be last
            if (pend_valid_ff) begin
               out_valid_in = 1'b1;
               out_kind_in  = pend_kind_ff;
               out_id_in    = pend_id_ff;
               out_rc_in    = pend_rc_ff;
               out_last_in  = 1'b0;
            end
            pend_valid_in = 1'b1;
            pend_kind_in  = stat.give_up ? KIND_GIVEN_UP : KIND_RESEND;
            pend_id_in    = rd_q.id;
            pend_rc_in    = rc_next;
         end
         OUT_FIN: begin
            out_valid_in  = 1'b1;
            out_kind_in   = pend_valid_ff ? pend_kind_ff : KIND_TICK_IDLE;
            out_id_in     = pend_valid_ff ? pend_id_ff : '0;
            out_rc_in     = pend_valid_ff ? pend_rc_ff : '0;
            out_last_in   = 1'b1;
            pend_valid_in = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         idx_ff        <= '0;
         now_ff        <= '0;
         timeout_ff    <= TMO_W'(2);
         max_ff        <= RC_W'(3);
         found_ff      <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         idx_ff        <= idx_in;
         now_ff        <= now_in;
         timeout_ff    <= timeout_in;
         max_ff        <= max_in;
         found_ff      <= found_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff        <= id_in;
      pend_kind_ff <= pend_kind_in;
      pend_id_ff   <= pend_id_in;
      pend_rc_ff   <= pend_rc_in;
      out_kind_ff  <= out_kind_in;
      out_id_ff    <= out_id_in;
      out_rc_ff    <= out_rc_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_rc_ff, out_id_ff, out_kind_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

// File: rtl/core/art_ctrl.sv
// Controller of the tracker: sequences add, ack search and tick scan.
// Depends on art_pkg.
module art_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  art_pkg::stat_type stat,
   output art_pkg::cmd_type  cmd
);
   import art_pkg::*;

   typedef enum logic [9:0] {
      S_IDLE    = 10'b0000000001,
      S_ADD     = 10'b0000000010,
      S_ACK_RD  = 10'b0000000100,
      S_ACK_CMP = 10'b0000001000,
      S_ACK_MV  = 10'b0000010000,
      S_ACK_FIN = 10'b0000100000,
      S_TK_RD   = 10'b0001000000,
      S_TK_EVAL = 10'b0010000000,
      S_TK_MV   = 10'b0100000000,
      S_TK_FIN  = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd        = '0;
      cmd.wr_sel = WR_ADD;
      cmd.out_sel = OUT_NONE;
      req_tready = 1'b0;
      state_in   = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.latch = 1'b1;
               unique case (stat.req_op)
                  OP_ADD: state_in = S_ADD;
                  OP_ACK: begin
                     cmd.idx_clr = 1'b1;
                     state_in    = S_ACK_RD;
                  end
                  OP_TICK: begin
                     cmd.idx_clr = 1'b1;
                     cmd.now_inc = 1'b1;
                     state_in    = S_TK_RD;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_ADD: begin
            if (stat.out_free) begin
               cmd.out_sel = OUT_ADD;
               if (!stat.full) begin
                  cmd.wr_en   = 1'b1;
                  cmd.wr_sel  = WR_ADD;
                  cmd.cnt_inc = 1'b1;
               end
               state_in = S_IDLE;
            end
         end
         S_ACK_RD: begin
            if (stat.idx_ge) begin
               state_in = S_ACK_FIN;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = S_ACK_CMP;
            end
         end
         S_ACK_CMP: begin
            if (stat.match) begin
               cmd.found_set = 1'b1;
               if (stat.idx_is_tail) begin
                  cmd.cnt_dec = 1'b1;
                  state_in    = S_ACK_FIN;
               end else begin
                  cmd.rd_en   = 1'b1;
                  cmd.rd_tail = 1'b1;
                  state_in    = S_ACK_MV;
               end
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_ACK_RD;
            end
         end
         S_ACK_MV: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = WR_MOVE;
            cmd.cnt_dec = 1'b1;
            state_in    = S_ACK_FIN;
         end
         S_ACK_FIN: begin
            if (stat.out_free) begin
               cmd.out_sel = OUT_ACK;
               state_in    = S_IDLE;
            end
         end
         S_TK_RD: begin
            if (stat.idx_ge) begin
               state_in = S_TK_FIN;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = S_TK_EVAL;
            end
         end
         S_TK_EVAL: begin
            if (!stat.due) begin
               cmd.idx_inc = 1'b1;
               state_in    = S_TK_RD;
            end else if (stat.pend_free) begin
               cmd.out_sel = OUT_EVAL;
               if (!stat.give_up) begin
                  cmd.wr_en   = 1'b1;
                  cmd.wr_sel  = WR_RESEND;
                  cmd.idx_inc = 1'b1;
                  state_in    = S_TK_RD;
               end else if (stat.idx_is_tail) begin
                  cmd.cnt_dec = 1'b1;
                  state_in    = S_TK_RD;
               end else begin
                  cmd.rd_en   = 1'b1;
                  cmd.rd_tail = 1'b1;
                  state_in    = S_TK_MV;
               end
            end
         end
         S_TK_MV: begin
            // slot is rescanned with the moved entry
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = WR_MOVE;
            cmd.cnt_dec = 1'b1;
            state_in    = S_TK_RD;
         end
         S_TK_FIN: begin
            if (stat.out_free) begin
               cmd.out_sel = OUT_FIN;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/core/ack_retransmit_tracker_unit.sv
// Ack/retransmit tracker: a compact table of messages waiting for an ack,
// with timed resend and give-up. Depends on art_pkg, art_ctrl, art_datapath.
//
// One request word at a time is taken. The next one is refused until the
// last result of the current one sits in the output register. An ack
// searches the table slot by slot; on a match the tail entry is moved into
// the freed slot unless the match is the tail itself. A tick scans every
// entry, refills the slot of each given-up entry from the tail and then
// rescans that slot. Each slot visited is first read from the table RAM,
// whose read is registered, and then compared or evaluated. Waiting on
// rsp_tready can stall an add, an ack or a tick. A tick's results come
// out in scan order, and rsp_tlast flags the last one. A tick with no due
// entry gives one idle word.
// The table holds TABLE_DEPTH entries, and no clearing pass is needed after
// reset. Op code 3 is taken and ignored.
module ack_retransmit_tracker_unit #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [art_pkg::REQ_W-1:0]  req_tdata,   // op[1:0], entry_id[33:2]
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [art_pkg::RSP_W-1:0]  rsp_tdata,   // kind[2:0], result_id[34:3],
                                                   // retry_count[38:35]
   output logic                       rsp_tlast,
   input  logic                       csr_we,
   input  logic [art_pkg::CSR_AW-1:0] csr_addr,
   input  logic [art_pkg::CSR_DW-1:0] csr_wdata
);
   import art_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   art_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   art_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: rtl/core/art_checker.sv
// Port-level checks of the tracker, bound to the top level.
// Depends on art_pkg and assert_macros.svh.
`include "assert_macros.svh"

module art_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [art_pkg::RSP_W-1:0] rsp_tdata,
   input logic                      rsp_tlast
);
   import art_pkg::*;

   logic              stall;
   logic [RSP_W:0]    rsp_word;
   logic [KIND_W-1:0] rsp_kind;
   logic [ID_W-1:0]   rsp_id;
   logic [RC_W-1:0]   rsp_rc;
   logic              retry_word;
   logic              idle_word;

   assign stall      = rsp_tvalid && !rsp_tready;
   assign rsp_word   = {rsp_tlast, rsp_tdata};
   assign rsp_kind   = rsp_tdata[2:0];
   assign rsp_id     = rsp_tdata[34:3];
   assign rsp_rc     = rsp_tdata[38:35];
   assign retry_word = (rsp_kind == KIND_RESEND) || (rsp_kind == KIND_GIVEN_UP);
   assign idle_word  = rsp_tvalid && (rsp_kind == KIND_TICK_IDLE);

   `ART_ASSERT(a_rsp_hold, clock, reset, stall |=> rsp_tvalid, "rsp word dropped while stalled")
   `ART_ASSERT(a_rsp_stable, clock, reset, stall |=> $stable(rsp_word), "rsp word changed in stall")
   `ART_ASSERT(a_rc_zero, clock, reset, rsp_tvalid && !retry_word |-> rsp_rc == '0, "stray retry count")
   `ART_ASSERT(a_idle_last, clock, reset, idle_word |-> rsp_tlast && rsp_id == '0, "idle word not alone")
   `ART_ASSERT_ALWAYS(a_reset_clear, clock, reset |=> !rsp_tvalid, "rsp valid after reset")

endmodule

bind ack_retransmit_tracker_unit art_checker u_art_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

// File: tb/tb.sv
// Self-checking testbench for ack_retransmit_tracker_unit: directed and random
// add/ack/tick words, checked against an in-bench model of the pending table.
// Depends on art_pkg and the tracker RTL only.
`timescale 1ns / 100ps

module tb;
   import art_pkg::*;

   localparam int DEPTH         = 64;
   localparam int SETTLE_CYCLES = 300;
   localparam int LIMIT_CYCLES  = 3000000;
   localparam int MAX_REPORTS   = 10;
   localparam logic [1:0] OP_NONE = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [ID_W-1:0]   id;
      logic [RC_W-1:0]   rc;
      logic              last;
   } reply_word_type;

   typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [REQ_W-1:0]    req_tdata = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_W-1:0]    rsp_tdata;
   logic                rsp_tlast;
   logic                csr_we = 1'b0;
   logic [CSR_AW-1:0]   csr_addr = '0;
   logic [CSR_DW-1:0]   csr_wdata = '0;

   // table image
   logic [ID_W-1:0]     tbl_id[DEPTH];
   logic [TIME_W-1:0]   tbl_sent[DEPTH];
   logic [RC_W-1:0]     tbl_rc[DEPTH];
   int unsigned         tbl_count = 0;
   logic [TIME_W-1:0]   sec_now = '0;
   logic [TMO_W-1:0]    cfg_timeout = 8'd2;
   logic [RC_W-1:0]     cfg_max_rc = 4'd3;

   reply_word_type      reply_q[$];
   int                  bad_words = 0;
   int                  words_checked = 0;
   int                  req_count = 0;
   int                  tick_count = 0;
   int                  drop_count = 0;
   int                  giveup_count = 0;
   int                  resend_count = 0;
   int                  cycle_count = 0;
   int                  burst_left = 0;
   rx_mode_type         rx_mode = RX_OPEN;
   int                  rx_mode_left = 0;

   ack_retransmit_tracker_unit #(.TABLE_DEPTH(DEPTH)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
                  reply_q.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   // receiver stall pattern
   always @(posedge clock) begin
      if (rx_mode_left == 0) begin
         rx_mode <= rx_mode_type'($urandom_range(0, 3));
         rx_mode_left <= $urandom_range(40, 300);
      end else begin
         rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
         RX_OPEN:   rsp_tready <= 1'b1;
         RX_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
         RX_SPARSE: rsp_tready <= ($urandom_range(0, 4) == 0);
         default:   rsp_tready <= ((cycle_count % 16) >= 12);
      endcase
   end

   function automatic void push_reply(logic [KIND_W-1:0] kind, logic [ID_W-1:0] id,
                                      logic [RC_W-1:0] rc);
      reply_word_type w;
      w.kind = kind;
      w.id = id;
      w.rc = rc;
      w.last = 1'b0;
      reply_q.push_back(w);
   endfunction

   // compact removal: tail entry moves into the freed slot
   function automatic void drop_slot(int unsigned slot);
      int unsigned tail;
      tail = tbl_count - 1;
      tbl_id[slot] = tbl_id[tail];
      tbl_sent[slot] = tbl_sent[tail];
      tbl_rc[slot] = tbl_rc[tail];
      tbl_count = tail;
   endfunction

   function automatic void track_request(logic [1:0] op, logic [ID_W-1:0] id);
      int unsigned i;
      int produced;
      logic found;
      logic [TIME_W-1:0] age;
      logic [RC_W-1:0] rc;
      reply_word_type w;
      produced = 0;
      found = 1'b0;
      req_count++;
      case (op)
         OP_ADD: begin
            if (tbl_count < DEPTH) begin
               tbl_id[tbl_count] = id;
               tbl_sent[tbl_count] = sec_now;
               tbl_rc[tbl_count] = '0;
               tbl_count++;
               push_reply(KIND_ADDED, id, '0);
            end else begin
               push_reply(KIND_DROPPED, id, '0);
               drop_count++;
            end
            produced = 1;
         end
         OP_ACK: begin
            for (i = 0; i < tbl_count && !found; i++) begin
               if (tbl_id[i] == id) begin
                  drop_slot(i);
                  found = 1'b1;
               end
            end
            push_reply(found ? KIND_ACK_MATCHED : KIND_ACK_UNMATCHED, id, '0);
            produced = 1;
         end
         OP_TICK: begin
            sec_now = sec_now + TIME_W'(1);
            tick_count++;
            i = 0;
            while (i < tbl_count) begin
               age = sec_now - tbl_sent[i];
               if (age < {24'd0, cfg_timeout}) begin
                  i++;
               end else begin
                  rc = tbl_rc[i];
                  if (rc != RC_MAX) rc = rc + 4'd1;
                  tbl_rc[i] = rc;
                  if (rc > cfg_max_rc) begin
                     push_reply(KIND_GIVEN_UP, tbl_id[i], rc);
                     drop_slot(i);
                     giveup_count++;
                  end else begin
                     push_reply(KIND_RESEND, tbl_id[i], rc);
                     tbl_sent[i] = sec_now;
                     resend_count++;
                     i++;
                  end
                  produced++;
               end
            end
            if (produced == 0) begin
               push_reply(KIND_TICK_IDLE, '0, '0);
               produced = 1;
            end
         end
         default: ;
      endcase
      if (produced != 0) begin
         w = reply_q.pop_back();
         w.last = 1'b1;
         reply_q.push_back(w);
      end
   endfunction

   always @(posedge clock) begin : check_replies
      reply_word_type got;
      reply_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind = rsp_tdata[2:0];
         got.id = rsp_tdata[34:3];
         got.rc = rsp_tdata[38:35];
         got.last = rsp_tlast;
         words_checked++;
         if (reply_q.size() == 0) begin
            bad_words++;
            if (bad_words <= MAX_REPORTS)
               $display("%0t: unexpected word kind=%0d id=%h rc=%0d last=%b", $realtime,
                        got.kind, got.id, got.rc, got.last);
         end else begin
            want = reply_q.pop_front();
            if (got !== want) begin
               bad_words++;
               if (bad_words <= MAX_REPORTS)
                  $display("%0t: mismatch exp kind=%0d id=%h rc=%0d last=%b,",
                           $realtime, want.kind, want.id, want.rc, want.last,
                           " got kind=%0d id=%h rc=%0d last=%b",
                           got.kind, got.id, got.rc, got.last);
            end
         end
      end
   end

   task automatic send_req(input logic [1:0] op, input logic [ID_W-1:0] id);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= {6'd0, id, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      track_request(op, id);
   endtask

   // stop sending, drain all replies, let the block finish any ignored word
   task automatic settle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (reply_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input logic [TMO_W-1:0] timeout, input logic [RC_W-1:0] max_rc);
      settle();
      csr_we <= 1'b1;
      csr_addr <= CSR_RETRY_TIMEOUT;
      csr_wdata <= timeout;
      @(posedge clock);
      cfg_timeout = timeout;
      csr_addr <= CSR_MAX_RETRIES;
      csr_wdata <= {4'd0, max_rc};
      @(posedge clock);
      cfg_max_rc = max_rc;
      csr_we <= 1'b0;
   endtask

   // reset defaults: timeout 2, 3 retries
   task automatic test_basic_lifecycle();
      send_req(OP_ACK, 32'h1234_5678);
      send_req(OP_TICK, 32'hDEAD_BEEF);
      send_req(OP_NONE, 32'hFFFF_FFFF);
      send_req(OP_ADD, 32'h0000_0000);
      send_req(OP_ADD, 32'hFFFF_FFFF);
      send_req(OP_ADD, 32'hA5A5_A5A5);
      send_req(OP_ADD, 32'hA5A5_A5A5);
      send_req(OP_ADD, 32'h5A5A_5A5A);
      send_req(OP_ACK, 32'hA5A5_A5A5);
      send_req(OP_TICK, 32'h0);
      send_req(OP_TICK, 32'h0);
      send_req(OP_ACK, 32'hFFFF_FFFF);
      repeat (6) send_req(OP_TICK, $urandom);
      send_req(OP_ACK, 32'h0000_0000);
      send_req(OP_TICK, 32'h0);
   endtask

   // fill to the brim, overflow, then give up everything in one tick
   task automatic test_full_table();
      logic [ID_W-1:0] first_id;
      logic [ID_W-1:0] last_id;
      configure(8'd1, 4'd0);
      first_id = $urandom;
      last_id = $urandom;
      send_req(OP_ADD, first_id);
      repeat (DEPTH - 2) send_req(OP_ADD, $urandom);
      send_req(OP_ADD, last_id);
      repeat (3) send_req(OP_ADD, $urandom);
      send_req(OP_ACK, last_id);
      send_req(OP_ACK, first_id);
      send_req(OP_ADD, last_id);
      send_req(OP_TICK, 32'h0);
      send_req(OP_TICK, 32'h0);
   endtask

   task automatic test_zero_timeout();
      configure(8'd0, 4'd2);
      repeat (5) send_req(OP_ADD, $urandom);
      repeat (4) send_req(OP_TICK, 32'h0);
   endtask

   // retry count pins at 15; unlimited resends, then a lower limit drops them
   task automatic test_retry_saturation();
      configure(8'd1, 4'd15);
      repeat (3) send_req(OP_ADD, $urandom);
      repeat (18) send_req(OP_TICK, 32'h0);
      configure(8'd1, 4'd14);
      send_req(OP_TICK, 32'h0);
   endtask

   // largest timeout keeps fresh entries quiet
   task automatic test_long_timeout();
      configure(8'd255, 4'd1);
      send_req(OP_ADD, 32'hFFFF_FFFF);
      send_req(OP_ADD, 32'h0000_0001);
      repeat (6) send_req(OP_TICK, 32'h0);
      send_req(OP_ACK, 32'h0000_0001);
      send_req(OP_ACK, 32'hFFFF_FFFF);
   endtask

   task automatic test_random_traffic();
      logic [ID_W-1:0] id_pool[12];
      int pick;
      for (int phase = 0; phase < 4; phase++) begin
         if (phase == 3)
            configure(TMO_W'($urandom_range(5, 40)), RC_W'($urandom_range(0, 15)));
         else
            configure(TMO_W'($urandom_range(1, 3)), RC_W'($urandom_range(0, 15)));
         foreach (id_pool[k]) id_pool[k] = $urandom;
         id_pool[0] = 32'h0000_0000;
         id_pool[1] = 32'hFFFF_FFFF;
         for (int n = 0; n < 35; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
               send_req(OP_ADD, ($urandom_range(0, 4) == 0) ? $urandom
                                                            : id_pool[$urandom_range(0, 11)]);
            else if (pick < 70)
               send_req(OP_ACK, ($urandom_range(0, 4) == 0) ? $urandom
                                                            : id_pool[$urandom_range(0, 11)]);
            else if (pick < 95)
               send_req(OP_TICK, $urandom);
            else
               send_req(OP_NONE, $urandom);
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_basic_lifecycle();
      test_full_table();
      test_zero_timeout();
      test_retry_saturation();
      test_long_timeout();
      test_random_traffic();
      settle();
      $display("Sent %0d request words (%0d ticks); checked %0d reply words.",
               req_count, tick_count, words_checked);
      $display("Seen %0d drops on a full table, %0d resends and %0d give-ups.",
               drop_count, resend_count, giveup_count);
      if (bad_words == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("%0d bad reply words", bad_words);
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
